>>> rtl/core/sigf_pkg.sv
package sigf_pkg;

    localparam int STORE_DEPTH   = 64;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int LEN_W         = 7;
    localparam int IDLE_W        = 16;
    localparam int BYTE_W        = 8;
    localparam int TYPE_W        = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_FRAME_DEF = 64;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RST = 16'd10;
    localparam logic [TYPE_W-1:0] FRAME_TYPE_RST   = 8'd0;

    localparam logic [1:0] CMD_BYTE  = 2'd0;
    localparam logic [1:0] CMD_TICK  = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [1:0] REASON_IDLE   = 2'd0;
    localparam logic [1:0] REASON_MAXLEN = 2'd1;
    localparam logic [1:0] REASON_FLUSH  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE   = 1'b1;

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [LEN_W-1:0]  frame_length;
        logic [1:0]        end_reason;
        logic [TYPE_W-1:0] type_tag;
        logic              last_byte;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHOW
    } t_state;

endpackage

>>> rtl/core/sigf_mem.sv
module sigf_mem (
    input  logic                         i_clk,
    input  sigf_pkg::t_mem_req           i_req,
    output logic [sigf_pkg::BYTE_W-1:0]  o_rdata
);
    import sigf_pkg::*;

    logic [BYTE_W-1:0] r_store [STORE_DEPTH];
    logic [BYTE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_store[i_req.waddr] <= i_req.wdata;
        end
    end

    // hold read data between reads so the shown word stays put under stall
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_store[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/sigf_ctrl.sv
module sigf_ctrl #(
    parameter int MAX_FRAME = sigf_pkg::MAX_FRAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [sigf_pkg::IDLE_W-1:0]  i_timeout,
    input  logic [sigf_pkg::TYPE_W-1:0]  i_frame_type,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  sigf_pkg::t_in_word           i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output sigf_pkg::t_out_word          o_out_word,
    output sigf_pkg::t_mem_req           o_mem_req,
    input  logic [sigf_pkg::BYTE_W-1:0]  i_mem_rdata
);
    import sigf_pkg::*;

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FRAME);

    t_state             r_state, n_state;
    logic [LEN_W-1:0]   r_count, n_count;
    logic [IDLE_W-1:0]  r_idle, n_idle;
    logic [ADDR_W-1:0]  r_rd_idx, n_rd_idx;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [1:0]         r_reason, n_reason;
    logic               r_pend, n_pend;
    logic [BYTE_W-1:0]  r_pend_byte, n_pend_byte;

    logic               acc_in;
    logic               has_data;
    logic [IDLE_W-1:0]  idle_inc;
    logic [LEN_W-1:0]   count_inc;
    logic               do_close;
    logic               do_append;
    logic               do_pend;
    logic [1:0]         close_reason;
    logic [LEN_W-1:0]   close_len;
    logic               out_take;
    logic               at_last;

    assign acc_in    = i_in_valid && (r_state == ST_IDLE);
    assign has_data  = (r_count != '0);
    assign idle_inc  = (r_idle == '1) ? r_idle : r_idle + 1'b1;
    assign count_inc = r_count + 1'b1;
    assign out_take  = (r_state == ST_SHOW) && !i_out_stall;
    assign at_last   = ({1'b0, r_rd_idx} == (r_len - 1'b1));

    // decide what the accepted word does
    always_comb begin
        do_close     = 1'b0;
        do_append    = 1'b0;
        do_pend      = 1'b0;
        close_reason = REASON_IDLE;
        close_len    = r_count;
        case (i_in_word.cmd)
            CMD_BYTE: begin
                if (has_data && (r_idle > i_timeout)) begin
                    // drain the old frame first, append this byte afterwards
                    do_close     = 1'b1;
                    do_pend      = 1'b1;
                    close_reason = REASON_IDLE;
                end else begin
                    do_append = 1'b1;
                    if (count_inc == MAX_LEN) begin
                        do_close     = 1'b1;
                        close_reason = REASON_MAXLEN;
                        close_len    = count_inc;
                    end
                end
            end
            CMD_TICK: begin
                if (has_data && (idle_inc > i_timeout)) begin
                    do_close     = 1'b1;
                    close_reason = REASON_IDLE;
                end
            end
            CMD_FLUSH: begin
                if (has_data) begin
                    do_close     = 1'b1;
                    close_reason = REASON_FLUSH;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_count     = r_count;
        n_idle      = r_idle;
        n_rd_idx    = r_rd_idx;
        n_len       = r_len;
        n_reason    = r_reason;
        n_pend      = r_pend;
        n_pend_byte = r_pend_byte;
        if (acc_in) begin
            if (i_in_word.cmd == CMD_BYTE) begin
                n_idle = '0;
            end else if (i_in_word.cmd == CMD_TICK) begin
                n_idle = idle_inc;
            end
            if (do_append && !do_close) begin
                n_count = count_inc;
            end
            if (do_close) begin
                n_count  = '0;
                n_len    = close_len;
                n_reason = close_reason;
                n_rd_idx = '0;
            end
            if (do_pend) begin
                n_pend      = 1'b1;
                n_pend_byte = i_in_word.data_byte;
            end
        end else if (out_take) begin
            if (at_last) begin
                if (r_pend) begin
                    n_count = LEN_W'(1);
                    n_pend  = 1'b0;
                end
            end else begin
                n_rd_idx = r_rd_idx + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (acc_in && do_close) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_SHOW;
            ST_SHOW: begin
                if (out_take) begin
                    n_state = at_last ? ST_IDLE : ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        o_out_valid = (r_state == ST_SHOW);

        o_out_word.out_byte     = i_mem_rdata;
        o_out_word.frame_length = r_len;
        o_out_word.end_reason   = r_reason;
        o_out_word.type_tag     = i_frame_type;
        o_out_word.last_byte    = at_last;

        o_mem_req.re    = (r_state == ST_READ);
        o_mem_req.raddr = r_rd_idx;
        o_mem_req.we    = 1'b0;
        o_mem_req.waddr = r_count[ADDR_W-1:0];
        o_mem_req.wdata = i_in_word.data_byte;
        if (acc_in && do_append) begin
            o_mem_req.we = 1'b1;
        end else if (out_take && at_last && r_pend) begin
            // the held byte opens the next frame
            o_mem_req.we    = 1'b1;
            o_mem_req.waddr = '0;
            o_mem_req.wdata = r_pend_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_idle  <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_idle  <= n_idle;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx    <= n_rd_idx;
        r_len       <= n_len;
        r_reason    <= n_reason;
        r_pend_byte <= n_pend_byte;
    end

endmodule

>>> rtl/core/serial_idle_gap_framer_top.sv
// Serial framer: words carry a received byte, a time tick or a flush. Bytes
// collect in a 64-entry frame memory; a frame closes on an idle gap (idle
// ticks above the timeout register), on reaching MAX_FRAME bytes, or on flush,
// and is then sent out one word per byte with length, close reason, type tag
// and a last-byte flag. A word that closes no frame leaves the input free for
// the next word. A word that closes a frame is accepted and then holds the
// input stalled while the frame drains: each byte is fetched by the frame
// memory's registered read and then shown on the output, where an output
// stall holds it. When a byte arrives after an idle gap, the old frame drains
// first and the new byte is stored once the last word of that frame is taken.
module serial_idle_gap_framer_top #(
    parameter int MAX_FRAME = sigf_pkg::MAX_FRAME_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [sigf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [sigf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  sigf_pkg::t_in_word                i_in_word,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output sigf_pkg::t_out_word               o_out_word
);
    import sigf_pkg::*;

    logic [IDLE_W-1:0] r_timeout;
    logic [TYPE_W-1:0] r_frame_type;
    t_mem_req          mem_req;
    logic [BYTE_W-1:0] mem_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= IDLE_TIMEOUT_RST;
            r_frame_type <= FRAME_TYPE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_IDLE_TIMEOUT: r_timeout    <= i_cfg_data[IDLE_W-1:0];
                REG_FRAME_TYPE:   r_frame_type <= i_cfg_data[TYPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    sigf_ctrl #(
        .MAX_FRAME (MAX_FRAME)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_timeout    (r_timeout),
        .i_frame_type (r_frame_type),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_word    (i_in_word),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_word   (o_out_word),
        .o_mem_req    (mem_req),
        .i_mem_rdata  (mem_rdata)
    );

    sigf_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(mem_req.we && mem_req.re))
        else $error("frame memory read and write in the same cycle");

    a_stall_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("input taken while a frame drains");

    a_last_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall && o_out_word.last_byte) |=> !o_out_valid)
        else $error("output continues past the last byte");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.frame_length != '0))
        else $error("empty frame emitted");
`endif

endmodule

>>> verif/serial_idle_gap_framer_top_test.sv
module serial_idle_gap_framer_top_test;
    import sigf_pkg::*;

    localparam int MAX_LEN       = MAX_FRAME_DEF;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int BIG_TICKS     = 6;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class frame_tracker;
        logic [IDLE_W-1:0] idle_limit = IDLE_TIMEOUT_RST;
        logic [TYPE_W-1:0] type_reg   = FRAME_TYPE_RST;
        logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
        int unsigned       byte_count = 0;
        logic [IDLE_W-1:0] idle_ticks = '0;
        t_out_word         expected_q [$];
        int unsigned       errors    = 0;
        int unsigned       words_in  = 0;
        int unsigned       words_out = 0;
        int unsigned       frames    = 0;
        int unsigned       closes [3] = '{default: 0};

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            if (idx == REG_IDLE_TIMEOUT)
                idle_limit = value[IDLE_W-1:0];
            else
                type_reg = value[TYPE_W-1:0];
        endfunction

        function void close_frame(logic [1:0] reason);
            t_out_word w;
            for (int k = 0; k < byte_count; k++) begin
                w.out_byte     = frame_bytes[k];
                w.frame_length = LEN_W'(byte_count);
                w.end_reason   = reason;
                w.type_tag     = type_reg;
                w.last_byte    = (k == byte_count - 1);
                expected_q.push_back(w);
            end
            closes[reason]++;
            frames++;
            byte_count = 0;
        endfunction

        function void take_word(t_in_word w);
            words_in++;
            case (w.cmd)
                CMD_BYTE: begin
                    // a stale open frame goes out before the new byte lands
                    if (byte_count > 0 && idle_ticks > idle_limit)
                        close_frame(REASON_IDLE);
                    frame_bytes[byte_count] = w.data_byte;
                    byte_count++;
                    idle_ticks = '0;
                    if (byte_count >= MAX_LEN)
                        close_frame(REASON_MAXLEN);
                end
                CMD_TICK: begin
                    // saturate, never wrap
                    if (idle_ticks != '1)
                        idle_ticks++;
                    if (byte_count > 0 && idle_ticks > idle_limit)
                        close_frame(REASON_IDLE);
                end
                CMD_FLUSH: begin
                    if (byte_count > 0)
                        close_frame(REASON_FLUSH);
                end
                default: ;
            endcase
        endfunction

        function void check_word(t_out_word got);
            t_out_word want;
            words_out++;
            if (expected_q.size() == 0) begin
                $error("output word 0x%h arrived with nothing expected", got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
                errors++;
            end
            if (got.frame_length !== want.frame_length) begin
                $error("frame_length: expected %0d, got %0d",
                       want.frame_length, got.frame_length);
                errors++;
            end
            if (got.end_reason !== want.end_reason) begin
                $error("end_reason: expected %0d, got %0d", want.end_reason, got.end_reason);
                errors++;
            end
            if (got.type_tag !== want.type_tag) begin
                $error("type_tag: expected %0d, got %0d", want.type_tag, got.type_tag);
                errors++;
            end
            if (got.last_byte !== want.last_byte) begin
                $error("last_byte: expected %0d, got %0d", want.last_byte, got.last_byte);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  in_valid  = 1'b0;
    t_in_word              in_word   = '0;
    logic                  out_stall = 1'b0;
    logic                  in_stall;
    logic                  out_valid;
    t_out_word             out_word;

    frame_tracker tracker = new;

    bit                tx_busy     = 1'b0;
    bit                rx_busy     = 1'b0;
    bit                hold_armed  = 1'b0;
    int unsigned       words_sent  = 0;
    logic [IDLE_W-1:0] cur_limit   = IDLE_TIMEOUT_RST;

    serial_idle_gap_framer_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word)
    );

    always #2 clk = ~clk;

    // mostly back to back, some short gaps, a few long ones
    function automatic int unsigned pick_gap(bit busy);
        if (!busy || $urandom_range(99) < 65)
            return 0;
        if ($urandom_range(99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic put_word(logic [1:0] cmd, logic [BYTE_W-1:0] data);
        t_in_word    w;
        int unsigned gap;
        gap         = pick_gap(tx_busy);
        w.cmd       = cmd;
        w.data_byte = data;
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        tracker.take_word(w);
        if (cmd != CMD_UNUSED)
            words_sent++;
    endtask

    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (tracker.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both registers back to back; only called with the block idle
    task automatic write_regs(logic [IDLE_W-1:0] idle_ticks, logic [TYPE_W-1:0] frame_tag);
        cfg_we   <= 1'b1;
        cfg_idx  <= REG_IDLE_TIMEOUT;
        cfg_data <= CFG_DATA_W'(idle_ticks);
        @(posedge clk);
        tracker.set_reg(REG_IDLE_TIMEOUT, CFG_DATA_W'(idle_ticks));
        cfg_idx  <= REG_FRAME_TYPE;
        cfg_data <= CFG_DATA_W'(frame_tag);
        @(posedge clk);
        tracker.set_reg(REG_FRAME_TYPE, CFG_DATA_W'(frame_tag));
        cfg_we    <= 1'b0;
        cur_limit = idle_ticks;
    endtask

    task automatic send_frame(int unsigned nbytes);
        int unsigned ticks;
        int unsigned ending;
        int unsigned tick_cap;
        tick_cap = (cur_limit <= 12) ? cur_limit + 1 : 3;
        for (int i = 0; i < nbytes; i++) begin
            put_word(CMD_BYTE, BYTE_W'($urandom));
            if ($urandom_range(3) == 0) begin
                ticks = $urandom_range(tick_cap);
                repeat (ticks) put_word(CMD_TICK, BYTE_W'($urandom));
            end
        end
        // close by flush, by an idle gap, or leave the frame open
        ending = $urandom_range(2);
        if (ending == 0 || (ending == 1 && cur_limit > 20))
            put_word(CMD_FLUSH, BYTE_W'($urandom));
        else if (ending == 1)
            repeat (cur_limit + 1) put_word(CMD_TICK, BYTE_W'($urandom));
    endtask

    task automatic run_phase(int unsigned quota);
        int unsigned stop_at;
        int unsigned pick;
        int unsigned nbytes;
        stop_at = words_sent + quota;
        while (words_sent < stop_at) begin
            pick = $urandom_range(9);
            if (pick < 7) begin
                nbytes = ($urandom_range(11) == 0) ? $urandom_range(20, MAX_LEN)
                                                    : $urandom_range(1, 8);
                send_frame(nbytes);
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 5))
                    put_word(2'($urandom_range(3)), BYTE_W'($urandom));
            end else begin
                drain_and_settle();
            end
        end
        drain_and_settle();
    endtask

    initial begin : receiver
        int unsigned stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (out_valid && !out_stall)
                tracker.check_word(out_word);
            if (hold_armed && out_valid) begin
                hold_armed = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0) begin
                stall_left = pick_gap(rx_busy);
            end
            if (stall_left != 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet = 0;
            else
                quiet++;
        end
        $display("** serial_idle_gap_framer_top: FAILED **");
        $finish;
    end

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values: flush, empty flush, unused command, idle close
        tx_busy = 1'b1;
        rx_busy = 1'b1;
        put_word(CMD_BYTE, 8'h00);
        put_word(CMD_BYTE, 8'hFF);
        put_word(CMD_FLUSH, 8'h00);
        put_word(CMD_FLUSH, 8'hFF);
        put_word(CMD_UNUSED, 8'hFF);
        put_word(CMD_BYTE, 8'h81);
        repeat (11) put_word(CMD_TICK, 8'h00);
        drain_and_settle();

        // zero timeout: the first tick closes
        write_regs(16'd0, 8'hFF);
        put_word(CMD_BYTE, 8'h7E);
        put_word(CMD_TICK, 8'h00);
        drain_and_settle();

        // lower the limit under an open frame so the next byte closes it first
        write_regs(16'd3, 8'hA5);
        put_word(CMD_BYTE, 8'h11);
        put_word(CMD_TICK, 8'h00);
        put_word(CMD_TICK, 8'h00);
        drain_and_settle();
        write_regs(16'd1, 8'hA5);
        put_word(CMD_BYTE, 8'h22);
        put_word(CMD_FLUSH, 8'h00);
        drain_and_settle();

        // largest timeout: ticks never close the frame, the flush does
        tx_busy = 1'b0;
        rx_busy = 1'b0;
        write_regs(16'hFFFF, 8'h3C);
        put_word(CMD_BYTE, 8'hC3);
        repeat (BIG_TICKS) put_word(CMD_TICK, 8'h00);
        put_word(CMD_FLUSH, 8'h00);
        drain_and_settle();

        tx_busy = 1'b1;
        rx_busy = 1'b1;
        write_regs(16'd0, 8'($urandom));
        run_phase(12);

        tx_busy = 1'b0;
        rx_busy = 1'b0;
        write_regs(16'd5, 8'($urandom));
        send_frame(MAX_LEN);
        run_phase(12);

        // receiver holds off for a long stretch while words keep coming
        tx_busy    = 1'b0;
        rx_busy    = 1'b1;
        hold_armed = 1'b1;
        write_regs(16'hFFFF, 8'h00);
        run_phase(12);

        tx_busy = 1'b1;
        rx_busy = 1'b1;
        write_regs(16'($urandom_range(1, 12)), 8'($urandom));
        run_phase(12);

        $display("Run took %0d input words and checked %0d output words over %0d frames.",
                 tracker.words_in, tracker.words_out, tracker.frames);
        $display("Frames closed by idle gap %0d, by maximum length %0d, by flush %0d.",
                 tracker.closes[REASON_IDLE], tracker.closes[REASON_MAXLEN],
                 tracker.closes[REASON_FLUSH]);
        if (tracker.errors == 0)
            $display("** serial_idle_gap_framer_top: PASSED **");
        else
            $display("** serial_idle_gap_framer_top: FAILED **");
        $finish;
    end

endmodule
